[rtl/stla_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stla_pkg
// shared types and constants of the scrolling text lane allocator
// ----------------------------------------------------------------------------
package stla_pkg;

    localparam int TIME_W  = 31;
    localparam int WID_W   = 12;
    localparam int SPD_W   = 11;
    localparam int CFG_W   = 12;
    localparam int LANE_W  = 5;
    localparam int ROW_W   = 12;
    localparam int CADDR_W = 2;

    // shared multiplier operand and product widths
    localparam int E60_W  = 38;
    localparam int MULA_W = 50;
    localparam int MULB_W = 12;
    localparam int MULP_W = MULA_W + MULB_W;
    localparam int PROD_W = 64;
    localparam int KWO_W  = 30;

    // configuration register indexes
    localparam logic [CADDR_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CADDR_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 12'd1280;
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 12'd720;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_READ = 9'b000000010,
        S_DIFF = 9'b000000100,
        S_MUL1 = 9'b000001000,
        S_MUL2 = 9'b000010000,
        S_MUL3 = 9'b000100000,
        S_MUL4 = 9'b001000000,
        S_CMP  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_DIFF = 3'd1,
        OP_MUL1 = 3'd2,
        OP_MUL2 = 3'd3,
        OP_MUL3 = 3'd4,
        OP_MUL4 = 3'd5
    } fit_op_t;

    typedef struct packed {
        logic [TIME_W-1:0] tstamp;
        logic [WID_W-1:0]  width;
        logic [SPD_W-1:0]  speed;
    } lane_rec_t;

    typedef struct packed {
        fit_op_t           op;
        logic [TIME_W-1:0] now;
        logic [SPD_W-1:0]  speed;
        logic [CFG_W-1:0]  screen_width;
    } fit_ctrl_t;

    typedef struct packed {
        logic clears;   // new item clears the old tail
        logic slower;   // new speed not above stored speed
        logic no_catch; // catch-up test holds
    } fit_stat_t;

endpackage

`default_nettype wire

[rtl/scrolling_text_lane_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scrolling_text_lane_allocator
// picks the lowest lane where a new scrolling text item will not catch up
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream (tdata: now_ms, item_width, item_speed).
// Each request gives one result on the m_ stream (tdata: found, lane,
// row_y). Lanes are scanned from 0 upward through one shared multiplier
// under a small sequencer; s_tready is high only while the sequencer idles.
// An empty lane ends the scan in S_READ. An occupied lane passes S_DIFF,
// S_MUL1 and S_MUL2, where it is rejected by the clearance test or taken
// as not faster; otherwise S_MUL3, S_MUL4 and S_CMP run the catch-up test.
// The scan stops at the first fitting lane; with no fit all LANES lanes
// are scanned, and the result is loaded from S_DONE.
// m_tvalid rises when the output register is loaded.
// The result sits in an output register; a stalled receiver holds it, and
// a finished scan waits in its last state until the register frees.
// Reset empties all lanes and sets screen_width 1280 and screen_height 720.
// The cfg port writes screen_width (index 0) or screen_height (index 1), and
// ignores other indexes; the user must write only while idle, which the block
// does not enforce. row_y uses screen_height / LANES, refreshed after a write.
// ----------------------------------------------------------------------------
module scrolling_text_lane_allocator #(
    parameter int LANES = 24
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // now_ms [30:0], item_width [42:31], item_speed [53:43], zero [55:54]
    input  wire logic [55:0]                     s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // found [0], lane [5:1], row_y [17:6], zero [23:18]
    output logic [23:0]                          m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [stla_pkg::CADDR_W-1:0]    cfg_addr,
    input  wire logic [stla_pkg::CFG_W-1:0]      cfg_data
);

    localparam int IDX_W  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int RCP_SH = 19;
    localparam int RCP_W  = RCP_SH + 1;
    localparam logic [RCP_W-1:0] RCP = RCP_W'((64'd1 << RCP_SH) / LANES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LANES - 1);

    stla_pkg::state_t               state_reg, state_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic                           found_reg, found_next;
    logic [stla_pkg::TIME_W-1:0]    now_reg;
    logic [stla_pkg::WID_W-1:0]     width_reg;
    logic [stla_pkg::SPD_W-1:0]     speed_reg;
    logic [stla_pkg::CFG_W-1:0]     sw_reg;
    logic [stla_pkg::CFG_W-1:0]     sh_reg;
    logic [stla_pkg::CFG_W-1:0]     qest_reg;
    logic [stla_pkg::CFG_W-1:0]     row_step_reg;
    logic [stla_pkg::CFG_W+RCP_W-1:0] qest_prod;
    logic [RCP_W-1:0]               qest_back;
    logic [RCP_W-1:0]               qest_rem;
    logic                           m_tvalid_reg;
    logic                           out_found_reg;
    logic [stla_pkg::LANE_W-1:0]    out_lane_reg;
    logic [stla_pkg::ROW_W-1:0]     out_row_reg;
    logic [IDX_W+stla_pkg::CFG_W-1:0] row_prod;
    logic                           accept;
    logic                           out_load;
    logic                           lane_used;
    logic                           store_we;
    stla_pkg::lane_rec_t            rec;
    stla_pkg::lane_rec_t            wrec;
    stla_pkg::fit_ctrl_t            fctrl;
    stla_pkg::fit_stat_t            fstat;

    assign s_tready = (state_reg == stla_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == stla_pkg::S_DONE) && (!m_tvalid_reg || m_tready);
    assign store_we = out_load && found_reg;

    assign wrec.tstamp = now_reg;
    assign wrec.width  = width_reg;
    assign wrec.speed  = speed_reg;

    stla_lane_store #(
        .LANES (LANES),
        .IDX_W (IDX_W)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (idx_reg),
        .rdata (rec),
        .used  (lane_used),
        .we    (store_we),
        .waddr (idx_reg),
        .wdata (wrec)
    );

    always_comb
    begin
        fctrl.now          = now_reg;
        fctrl.speed        = speed_reg;
        fctrl.screen_width = sw_reg;
        case (state_reg)
            stla_pkg::S_DIFF: fctrl.op = stla_pkg::OP_DIFF;
            stla_pkg::S_MUL1: fctrl.op = stla_pkg::OP_MUL1;
            stla_pkg::S_MUL2: fctrl.op = stla_pkg::OP_MUL2;
            stla_pkg::S_MUL3: fctrl.op = stla_pkg::OP_MUL3;
            stla_pkg::S_MUL4: fctrl.op = stla_pkg::OP_MUL4;
            default:          fctrl.op = stla_pkg::OP_NONE;
        endcase
    end

    stla_fit_unit u_fit (
        .clk  (clk),
        .ctrl (fctrl),
        .rec  (rec),
        .stat (fstat)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        case (state_reg)
            stla_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = stla_pkg::S_READ;
                end
            end
            stla_pkg::S_READ:
            begin
                if (!lane_used)
                begin
                    found_next = 1'b1;
                    state_next = stla_pkg::S_DONE;
                end
                else
                begin
                    state_next = stla_pkg::S_DIFF;
                end
            end
            stla_pkg::S_DIFF:
            begin
                state_next = stla_pkg::S_MUL1;
            end
            stla_pkg::S_MUL1:
            begin
                state_next = stla_pkg::S_MUL2;
            end
            stla_pkg::S_MUL2:
            begin
                if (!fstat.clears)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = stla_pkg::S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = stla_pkg::S_READ;
                    end
                end
                else if (fstat.slower)
                begin
                    found_next = 1'b1;
                    state_next = stla_pkg::S_DONE;
                end
                else
                begin
                    state_next = stla_pkg::S_MUL3;
                end
            end
            stla_pkg::S_MUL3:
            begin
                state_next = stla_pkg::S_MUL4;
            end
            stla_pkg::S_MUL4:
            begin
                state_next = stla_pkg::S_CMP;
            end
            stla_pkg::S_CMP:
            begin
                if (fstat.no_catch)
                begin
                    found_next = 1'b1;
                    state_next = stla_pkg::S_DONE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = stla_pkg::S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = stla_pkg::S_READ;
                end
            end
            stla_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = stla_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = stla_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= stla_pkg::S_IDLE;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            sw_reg       <= stla_pkg::SCREEN_WIDTH_RST;
            sh_reg       <= stla_pkg::SCREEN_HEIGHT_RST;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we && cfg_addr == stla_pkg::CFG_SCREEN_WIDTH)
            begin
                sw_reg <= cfg_data;
            end
            if (cfg_we && cfg_addr == stla_pkg::CFG_SCREEN_HEIGHT)
            begin
                sh_reg <= cfg_data;
            end
        end
    end

    // row step = screen_height / LANES by reciprocal estimate and one correction
    assign qest_prod = sh_reg * RCP;
    assign qest_back = RCP_W'(qest_reg * LANES);
    assign qest_rem  = RCP_W'(sh_reg) - qest_back;

    always_ff @(posedge clk)
    begin
        qest_reg <= qest_prod[RCP_SH +: stla_pkg::CFG_W];
        if (qest_rem >= RCP_W'(LANES))
        begin
            row_step_reg <= qest_reg + 1'b1;
        end
        else
        begin
            row_step_reg <= qest_reg;
        end
    end

    assign row_prod = idx_reg * row_step_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg   <= s_tdata[30:0];
            width_reg <= s_tdata[42:31];
            speed_reg <= s_tdata[53:43];
        end
        if (out_load)
        begin
            out_found_reg <= found_reg;
            out_lane_reg  <= found_reg ? stla_pkg::LANE_W'(idx_reg) : '0;
            out_row_reg   <= found_reg ? row_prod[stla_pkg::ROW_W-1:0] : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_row_reg, out_lane_reg, out_found_reg};

endmodule

`default_nettype wire

[rtl/stla_lane_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stla_lane_store
// per-lane record memory with registered read and occupancy flags
// ----------------------------------------------------------------------------
module stla_lane_store #(
    parameter int LANES = 24,
    parameter int IDX_W = 5
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [IDX_W-1:0]     raddr,
    output stla_pkg::lane_rec_t       rdata,
    output logic                      used,
    input  wire logic                 we,
    input  wire logic [IDX_W-1:0]     waddr,
    input  wire stla_pkg::lane_rec_t  wdata
);

    stla_pkg::lane_rec_t lane_mem [LANES];
    logic [LANES-1:0]    used_reg;
    stla_pkg::lane_rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            lane_mem[waddr] <= wdata;
        end
        rdata_reg <= lane_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (we)
        begin
            used_reg[waddr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;
    assign used  = used_reg[raddr];

endmodule

`default_nettype wire

[rtl/stla_fit_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stla_fit_unit
// lane fit datapath around one shared signed multiplier
// ----------------------------------------------------------------------------
module stla_fit_unit (
    input  wire logic                 clk,
    input  wire stla_pkg::fit_ctrl_t  ctrl,
    input  wire stla_pkg::lane_rec_t  rec,
    output stla_pkg::fit_stat_t       stat
);

    logic signed [stla_pkg::TIME_W:0]         elapsed;
    logic signed [stla_pkg::E60_W-1:0]        elapsed_x;
    logic signed [stla_pkg::E60_W-1:0]        e60_reg;
    logic signed [stla_pkg::E60_W-1:0]        e60_next;
    logic [stla_pkg::KWO_W-1:0]               kwo;
    logic signed [stla_pkg::PROD_W-1:0]       kwo_s;
    logic signed [stla_pkg::MULA_W-1:0]       mul_a;
    logic signed [stla_pkg::MULB_W-1:0]       mul_b;
    logic signed [stla_pkg::MULP_W-1:0]       mul_p;
    logic signed [stla_pkg::PROD_W-1:0]       prod_reg;
    logic signed [stla_pkg::PROD_W-1:0]       prod_next;
    logic signed [stla_pkg::PROD_W-1:0]       lead_full;
    logic signed [stla_pkg::MULA_W-1:0]       lead_reg;
    logic signed [stla_pkg::PROD_W-1:0]       rhs_reg;
    logic signed [stla_pkg::PROD_W-1:0]       rhs_next;
    logic [stla_pkg::MULB_W-1:0]              sn_ext;
    logic [stla_pkg::MULB_W-1:0]              so_ext;

    assign sn_ext = {1'b0, ctrl.speed};
    assign so_ext = {1'b0, rec.speed};

    assign elapsed   = $signed({1'b0, ctrl.now}) - $signed({1'b0, rec.tstamp});
    assign elapsed_x = stla_pkg::E60_W'(elapsed);
    // times 60 as 64 - 4
    assign e60_next  = (elapsed_x <<< 6) - (elapsed_x <<< 2);

    // width times 256000 = 2^18 - 2^12 - 2^11
    assign kwo   = ({rec.width, 18'b0}) - (stla_pkg::KWO_W'({rec.width, 12'b0}))
                 - (stla_pkg::KWO_W'({rec.width, 11'b0}));
    assign kwo_s = $signed({{(stla_pkg::PROD_W - stla_pkg::KWO_W){1'b0}}, kwo});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.op)
            stla_pkg::OP_MUL1:
            begin
                mul_a = stla_pkg::MULA_W'(e60_reg);
                mul_b = $signed(sn_ext);
            end
            stla_pkg::OP_MUL2:
            begin
                mul_a = stla_pkg::MULA_W'(e60_reg);
                mul_b = $signed(so_ext);
            end
            stla_pkg::OP_MUL3:
            begin
                mul_a = $signed({{(stla_pkg::MULA_W - stla_pkg::CFG_W){1'b0}},
                                 ctrl.screen_width});
                mul_b = $signed(sn_ext - so_ext);
            end
            stla_pkg::OP_MUL4:
            begin
                mul_a = lead_reg;
                mul_b = $signed(sn_ext);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign prod_next = stla_pkg::PROD_W'(mul_p);
    assign lead_full = prod_reg - kwo_s;
    // product here is screen width times speed difference, scaled by 256000
    assign rhs_next  = (prod_reg <<< 18) - (prod_reg <<< 12) - (prod_reg <<< 11);

    always_ff @(posedge clk)
    begin
        if (ctrl.op == stla_pkg::OP_DIFF)
        begin
            e60_reg <= e60_next;
        end
        if (ctrl.op == stla_pkg::OP_MUL1 || ctrl.op == stla_pkg::OP_MUL2
            || ctrl.op == stla_pkg::OP_MUL3 || ctrl.op == stla_pkg::OP_MUL4)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.op == stla_pkg::OP_MUL3)
        begin
            lead_reg <= lead_full[stla_pkg::MULA_W-1:0];
        end
        if (ctrl.op == stla_pkg::OP_MUL4)
        begin
            rhs_reg <= rhs_next;
        end
    end

    assign stat.clears   = (prod_reg > kwo_s);
    assign stat.slower   = (ctrl.speed <= rec.speed);
    assign stat.no_catch = (prod_reg > rhs_reg);

endmodule

`default_nettype wire
